// ----- rtl/core/iruwr_pkg.sv -----
// Package for the windowed IR UART receiver core.
// Holds the item types, register codes and reset constants; depends on nothing.
package iruwr_pkg;

   localparam int unsigned BIT_TICKS_W  = 16;
   localparam int unsigned WINDOW_W     = 10;
   localparam int unsigned WAIT_W       = 22;
   localparam int unsigned TICK_W       = 20;
   localparam int unsigned SLOT_W       = 4;
   localparam int unsigned CHAR_W       = 7;
   localparam int unsigned CSR_ADDR_W   = 4;
   localparam int unsigned CSR_DATA_W   = 32;

   localparam logic [BIT_TICKS_W-1:0] BIT_TICKS_RESET    = 16'd417;
   localparam logic [WINDOW_W-1:0]    WIN_START_RESET    = 10'd40;
   localparam logic [WINDOW_W-1:0]    WIN_END_RESET      = 10'd20;
   localparam logic [3:0]             FRAME_BITS         = 4'd10;
   localparam logic [CHAR_W-1:0]      CHAR_MASK          = 7'h7F;
   localparam logic [SLOT_W-1:0]      SLOT_LAST          = 4'd15;
   localparam logic [SLOT_W-1:0]      SLOT_DATA_FIRST    = 4'd1;
   localparam logic [SLOT_W-1:0]      SLOT_DATA_LAST     = 4'd8;

   localparam logic [1:0] REG_BIT_TICKS    = 2'd0;
   localparam logic [1:0] REG_WIN_START    = 2'd1;
   localparam logic [1:0] REG_WIN_END      = 2'd2;

   localparam logic KIND_CHAR    = 1'b0;
   localparam logic KIND_TIMEOUT = 1'b1;

   typedef struct packed {
      logic              rx_level;
      logic [WAIT_W-1:0] wait_limit;
   } req_item_type;

   typedef struct packed {
      logic              kind;
      logic [CHAR_W-1:0] char_value;
   } rsp_item_type;

endpackage

// ----- rtl/core/ir_uart_window_receiver_core.sv -----
// Windowed pulse receiver for an optical 7E1 line: one line sample per item.
// A result is registered into the result queue when the item that causes it is accepted.
// Throughput: one item per cycle while input is not stalled; the frame logic is a single registered pass per sample.
// A two-entry result queue lets input continue while one result waits; input stalls
// only when both entries are full. Synchronous reset clears all control state and
// loads the register reset values; no clearing pass is needed.
module ir_uart_window_receiver_core
   import iruwr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_item_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_item_type          rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [BIT_TICKS_W-1:0] bit_ticks_ff;
   logic [WINDOW_W-1:0]    win_start_ff;
   logic [WINDOW_W-1:0]    win_end_ff;

   logic                   receiving_ff, receiving_in;
   logic [TICK_W-1:0]      tick_ff, tick_in;
   logic [WAIT_W-1:0]      idle_ff, idle_in;
   logic [7:0]             raw_ff, raw_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;

   logic                   head_valid_ff, head_valid_in;
   logic                   tail_valid_ff, tail_valid_in;
   rsp_item_type           head_ff, head_in;
   rsp_item_type           tail_ff, tail_in;

   logic                   csr_write;
   logic                   accept;
   logic                   pop;
   logic                   push;
   rsp_item_type           result;

   logic [TICK_W-1:0]      cur_tick;
   logic [SLOT_W-1:0]      cur_slot;
   logic [TICK_W-1:0]      cur_start;
   logic [TICK_W-1:0]      cur_end;
   logic [7:0]             cur_raw;
   logic [TICK_W:0]        end_plus;
   logic                   slot_step;
   logic [SLOT_W-1:0]      slot_c;
   logic [TICK_W-1:0]      start_c;
   logic [TICK_W-1:0]      end_c;
   logic                   hit;
   logic [2:0]             hit_index;
   logic [7:0]             raw_c;
   logic [TICK_W-1:0]      frame_len;
   logic                   frame_done;
   logic [WAIT_W:0]        idle_next;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ticks_ff <= BIT_TICKS_RESET;
         win_start_ff <= WIN_START_RESET;
         win_end_ff   <= WIN_END_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_BIT_TICKS: begin
               bit_ticks_ff <= csr_pwdata[BIT_TICKS_W-1:0];
            end
            REG_WIN_START: begin
               win_start_ff <= csr_pwdata[WINDOW_W-1:0];
            end
            REG_WIN_END: begin
               win_end_ff <= csr_pwdata[WINDOW_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_BIT_TICKS: csr_prdata = CSR_DATA_W'(bit_ticks_ff);
         REG_WIN_START: csr_prdata = CSR_DATA_W'(win_start_ff);
         REG_WIN_END:   csr_prdata = CSR_DATA_W'(win_end_ff);
         default:       csr_prdata = '0;
      endcase
   end

   assign req_stall = tail_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = head_valid_ff;
   assign rsp_data  = head_ff;
   assign pop       = head_valid_ff && !rsp_stall;

   // The start tick of a frame is processed with the initial frame values.
   assign cur_tick  = receiving_ff ? tick_ff       : '0;
   assign cur_slot  = receiving_ff ? slot_ff       : '0;
   assign cur_raw   = receiving_ff ? raw_ff        : '0;

   // Slot bounds follow the current bit period on every tick.
   assign cur_start = TICK_W'(cur_slot) * TICK_W'(bit_ticks_ff);
   assign cur_end   = cur_start + TICK_W'(bit_ticks_ff);

   assign end_plus  = (TICK_W+1)'(cur_end) + (TICK_W+1)'(bit_ticks_ff);
   assign slot_step = (bit_ticks_ff != '0) && (cur_slot != SLOT_LAST) && (cur_tick >= cur_end);
   assign slot_c    = slot_step ? cur_slot + 1'b1 : cur_slot;
   assign start_c   = slot_step ? cur_end : cur_start;
   assign end_c     = slot_step ? end_plus[TICK_W-1:0] : cur_end;

   assign hit = !req_data.rx_level
             && (slot_c >= SLOT_DATA_FIRST) && (slot_c <= SLOT_DATA_LAST)
             && ((TICK_W+1)'(cur_tick) >= (TICK_W+1)'(start_c) + (TICK_W+1)'(win_start_ff))
             && ((TICK_W+1)'(cur_tick) + (TICK_W+1)'(win_end_ff) < (TICK_W+1)'(end_c));
   assign hit_index = 3'(slot_c - SLOT_DATA_FIRST);

   always_comb begin
      raw_c = cur_raw;
      if (hit) begin
         raw_c[hit_index] = 1'b1;
      end
   end

   assign frame_len  = TICK_W'(bit_ticks_ff) * TICK_W'(FRAME_BITS);
   assign frame_done = ((TICK_W+1)'(cur_tick) + 1'b1) >= (TICK_W+1)'(frame_len);
   assign idle_next  = (WAIT_W+1)'(idle_ff) + 1'b1;

   always_comb begin
      receiving_in  = receiving_ff;
      tick_in       = tick_ff;
      idle_in       = idle_ff;
      raw_in        = raw_ff;
      slot_in       = slot_ff;
      push          = 1'b0;
      result        = '0;
      if (accept) begin
         if (!receiving_ff && req_data.rx_level) begin
            if (idle_next > (WAIT_W+1)'(req_data.wait_limit)) begin
               idle_in     = '0;
               push        = 1'b1;
               result.kind = KIND_TIMEOUT;
            end else begin
               idle_in = idle_next[WAIT_W-1:0];
            end
         end else begin
            if (!receiving_ff) begin
               idle_in = '0;
            end
            if (frame_done) begin
               receiving_in      = 1'b0;
               tick_in           = '0;
               slot_in           = '0;
               push              = 1'b1;
               result.kind       = KIND_CHAR;
               result.char_value = ~raw_c[CHAR_W-1:0] & CHAR_MASK;
            end else begin
               receiving_in  = 1'b1;
               tick_in       = cur_tick + 1'b1;
               slot_in       = slot_c;
               raw_in        = raw_c;
            end
         end
      end
   end

   always_comb begin
      head_valid_in = head_valid_ff;
      tail_valid_in = tail_valid_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      if (pop) begin
         head_valid_in = tail_valid_ff;
         head_in       = tail_ff;
         tail_valid_in = 1'b0;
      end
      if (push) begin
         if (!head_valid_in) begin
            head_valid_in = 1'b1;
            head_in       = result;
         end else begin
            tail_valid_in = 1'b1;
            tail_in       = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         receiving_ff  <= 1'b0;
         tick_ff       <= '0;
         idle_ff       <= '0;
         raw_ff        <= '0;
         slot_ff       <= '0;
         head_valid_ff <= 1'b0;
         tail_valid_ff <= 1'b0;
      end else begin
         receiving_ff  <= receiving_in;
         tick_ff       <= tick_in;
         idle_ff       <= idle_in;
         raw_ff        <= raw_in;
         slot_ff       <= slot_in;
         head_valid_ff <= head_valid_in;
         tail_valid_ff <= tail_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff       <= head_in;
      tail_ff       <= tail_in;
   end

   // The second queue entry is only ever filled behind a valid head.
   a_tail_behind_head: assert property (@(posedge clock) disable iff (reset)
      tail_valid_ff |-> head_valid_ff)
      else $error("result queue tail valid without head");

   // Outside a frame the frame counters are parked at zero.
   a_idle_counters: assert property (@(posedge clock) disable iff (reset)
      !receiving_ff |-> (tick_ff == '0) && (slot_ff == '0))
      else $error("frame counters not cleared outside a frame");

   // The end of a frame always leaves a result waiting at the output.
   a_frame_end_result: assert property (@(posedge clock) disable iff (reset)
      ($fell(receiving_ff) && !$past(reset)) |-> head_valid_ff)
      else $error("frame ended without a result");

   // A timeout item never carries a character.
   a_timeout_empty: assert property (@(posedge clock) disable iff (reset)
      (head_valid_ff && (head_ff.kind == KIND_TIMEOUT)) |-> (head_ff.char_value == '0))
      else $error("timeout item with nonzero character");

endmodule
